FILE: hw/rtl/fqs_pkg.sv
// shared types and constants of the fetch queue with squash
`default_nettype none

package fqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS         = 32;
    localparam int RESULT_CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int MACRO_MAX           = 15;

    localparam int TAG_W    = 16;
    localparam int SIZE_W   = 4;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;
    localparam int BYTES_W  = 9;
    localparam int TRACE_W  = 6;

    localparam int FLAG_TRACE_BIT = 0;
    localparam int FLAG_FIRST_BIT = 1;
    localparam int FLAG_SPEC_BIT  = 2;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_RECOVER = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_SHIFT,
        S_CHECK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic [2:0]        flags;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic             rvalid;
        logic [TAG_W-1:0] tag;
        status_t          status;
        logic             last;
    } emit_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fetch_queue_squash_top.sv
// ordered micro-op fetch queue with indexed remove and speculative squash
`default_nettype none

// Ordered micro-op fetch queue for one thread, held in a single-port-write,
// registered-read entry memory. Push, a rejected command and an unused action
// code give one result beat. A remove reads the entry at its position, then
// the compaction loop moves each younger entry down one slot at a time through
// the memory port, and then the result beat is sent. A recover reads the
// youngest entry, checks its speculative flag and reports it, entry by entry;
// it gives one beat per squashed entry, at most 32 per command (one beat with
// no removal if nothing is squashed); the last beat carries tlast. The input
// is not ready while a command is in progress or the output register holds a
// beat that is not being taken.
module fetch_queue_squash_top #(
    parameter int QUEUE_DEPTH = fqs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // uop_tag[15:0], macro_size[19:16], from_trace_cache[20], first_of_macro[21],
    // speculative[22], position[27:23], zero fill[31:28]
    input  wire logic [31:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // removed_tag[15:0], status[17:16], entry_count[23:18], byte_occupancy[32:24],
    // trace_occupancy[38:33], zero fill[39]
    output logic [39:0]      m_axis_tdata,
    // removed_valid[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    import fqs_pkg::*;

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int BW   = $clog2(QUEUE_DEPTH * MACRO_MAX + 1);
    localparam int PCW  = (CW > POS_W) ? CW : POS_W;
    localparam int SATW = 16;

    // input fields
    logic [TAG_W-1:0]  in_tag;
    logic [SIZE_W-1:0] in_size;
    logic              in_tc;
    logic              in_first;
    logic              in_spec;
    logic [POS_W-1:0]  in_pos;
    action_t           in_action;
    logic              in_acc;

    assign in_tag    = s_axis_tdata[15:0];
    assign in_size   = s_axis_tdata[19:16];
    assign in_tc     = s_axis_tdata[20];
    assign in_first  = s_axis_tdata[21];
    assign in_spec   = s_axis_tdata[22];
    assign in_pos    = s_axis_tdata[27:23];
    assign in_action = action_t'(s_axis_tuser);

    // control state
    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [BW-1:0]           bytes_reg, bytes_next;
    logic [CW-1:0]           trace_reg, trace_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [RESULT_CNT_W-1:0] n_reg, n_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]        pend_tag_reg, pend_tag_next;

    // entry memory
    entry_t        entry_mem [QUEUE_DEPTH];
    entry_t        rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // output register
    logic               out_valid_reg;
    logic               out_rvalid_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic [TRACE_W-1:0] out_trace_reg;
    logic               out_last_reg;
    logic               out_free;
    emit_t              emit;

    // shared take unit: counters after taking out the entry in rd_data_reg
    logic [CW-1:0] take_count;
    logic [BW-1:0] take_bytes;
    logic [CW-1:0] take_trace;
    logic          rd_tc;
    logic          rd_first;
    logic          rd_spec;

    logic          pos_ok;
    logic [CW-1:0] idx_p1_c;
    logic [RESULT_CNT_W-1:0] n_inc;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign rd_tc    = rd_data_reg.flags[FLAG_TRACE_BIT];
    assign rd_first = rd_data_reg.flags[FLAG_FIRST_BIT];
    assign rd_spec  = rd_data_reg.flags[FLAG_SPEC_BIT];

    always_comb
    begin
        take_count = (count_reg != '0) ? count_reg - CW'(1) : '0;
        take_bytes = bytes_reg;
        take_trace = trace_reg;
        if (!rd_tc && rd_first)
        begin
            take_bytes = (bytes_reg >= BW'(rd_data_reg.size))
                         ? bytes_reg - BW'(rd_data_reg.size) : '0;
        end
        if (rd_tc)
        begin
            take_trace = (trace_reg != '0) ? trace_reg - CW'(1) : '0;
        end
    end

    assign pos_ok   = PCW'(in_pos) < PCW'(count_reg);
    assign idx_p1_c = CW'(idx_reg) + CW'(1);
    assign n_inc    = n_reg + RESULT_CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            bytes_reg      <= '0;
            trace_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            trace_reg      <= trace_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_tag_reg <= pend_tag_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        trace_next      = trace_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        emit            = '0;
        emit.status     = STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_action)
                        ACT_PUSH:
                        begin
                            emit.en   = 1'b1;
                            emit.last = 1'b1;
                            if (count_reg >= CW'(QUEUE_DEPTH))
                            begin
                                emit.status = STAT_FULL;
                            end
                            else
                            begin
                                mem_we                          = 1'b1;
                                mem_waddr                       = AW'(count_reg);
                                mem_wdata.tag                   = in_tag;
                                mem_wdata.size                  = in_size;
                                mem_wdata.flags[FLAG_TRACE_BIT] = in_tc;
                                mem_wdata.flags[FLAG_FIRST_BIT] = in_first;
                                mem_wdata.flags[FLAG_SPEC_BIT]  = in_spec;
                                count_next = count_reg + CW'(1);
                                if (!in_tc && in_first)
                                begin
                                    bytes_next = bytes_reg + BW'(in_size);
                                end
                                if (in_tc)
                                begin
                                    trace_next = trace_reg + CW'(1);
                                end
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                emit.en     = 1'b1;
                                emit.last   = 1'b1;
                                emit.status = STAT_BAD_POS;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(in_pos);
                                idx_next   = AW'(in_pos);
                                state_next = S_TAKE;
                            end
                        end
                        ACT_RECOVER:
                        begin
                            if (count_reg == '0)
                            begin
                                emit.en   = 1'b1;
                                emit.last = 1'b1;
                            end
                            else
                            begin
                                mem_re          = 1'b1;
                                mem_raddr       = AW'(count_reg - CW'(1));
                                n_next          = '0;
                                pend_valid_next = 1'b0;
                                state_next      = S_CHECK;
                            end
                        end
                        default:
                        begin
                            emit.en   = 1'b1;
                            emit.last = 1'b1;
                        end
                    endcase
                end
            end
            S_TAKE:
            begin
                count_next    = take_count;
                bytes_next    = take_bytes;
                trace_next    = take_trace;
                pend_tag_next = rd_data_reg.tag;
                if (CW'(idx_reg) < take_count)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg + AW'(1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_SHIFT:
            begin
                // move entry idx+1 down into idx, fetch idx+2 meanwhile
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_data_reg;
                idx_next  = idx_reg + AW'(1);
                if (idx_p1_c < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_p1_c + CW'(1));
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_CHECK:
            begin
                if (pend_valid_reg)
                begin
                    // report the held removal once we know whether more follow
                    if (out_free)
                    begin
                        emit.en         = 1'b1;
                        emit.rvalid     = 1'b1;
                        emit.tag        = pend_tag_reg;
                        emit.last       = !rd_spec;
                        pend_valid_next = 1'b0;
                        if (!rd_spec)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (!rd_spec)
                begin
                    if (out_free)
                    begin
                        emit.en    = 1'b1;
                        emit.last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    count_next      = take_count;
                    bytes_next      = take_bytes;
                    trace_next      = take_trace;
                    pend_tag_next   = rd_data_reg.tag;
                    pend_valid_next = 1'b1;
                    n_next          = n_inc;
                    if ((take_count == '0) || (n_inc == RESULT_CNT_W'(MAX_RESULTS)))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(take_count - CW'(1));
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit.en         = 1'b1;
                    emit.rvalid     = 1'b1;
                    emit.tag        = pend_tag_reg;
                    emit.last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[mem_raddr];
        end
    end

    // counter snapshots, saturated to the field widths
    logic [SATW-1:0] sat_count;
    logic [SATW-1:0] sat_bytes;
    logic [SATW-1:0] sat_trace;

    assign sat_count = SATW'(count_next);
    assign sat_bytes = SATW'(bytes_next);
    assign sat_trace = SATW'(trace_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.en)
        begin
            out_rvalid_reg <= emit.rvalid;
            out_tag_reg    <= emit.tag;
            out_status_reg <= emit.status;
            out_last_reg   <= emit.last;
            out_count_reg  <= (sat_count > SATW'((1 << COUNT_W) - 1))
                              ? COUNT_W'((1 << COUNT_W) - 1) : sat_count[COUNT_W-1:0];
            out_bytes_reg  <= (sat_bytes > SATW'((1 << BYTES_W) - 1))
                              ? BYTES_W'((1 << BYTES_W) - 1) : sat_bytes[BYTES_W-1:0];
            out_trace_reg  <= (sat_trace > SATW'((1 << TRACE_W) - 1))
                              ? TRACE_W'((1 << TRACE_W) - 1) : sat_trace[TRACE_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_trace_reg, out_bytes_reg, out_count_reg,
                            out_status_reg, out_tag_reg};
    assign m_axis_tuser  = out_rvalid_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (CW'(idx_reg) < count_reg))
        else $error("compaction index past the last entry");

    a_no_accept_on_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input ready while result beat is stalled");

    a_squash_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RESULT_CNT_W'(MAX_RESULTS))
        else $error("squash count past result limit");

    a_held_removal: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && (state_reg == S_CHECK)) |-> (n_reg != '0))
        else $error("held squash result without a squashed entry");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_fetch_queue_squash_top.sv
// self-checking testbench of the fetch queue with squash: directed and random beats
module tb_fetch_queue_squash_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    localparam int          DEPTH        = DEFAULT_QUEUE_DEPTH;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_ITEMS  = 120;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;

    typedef struct {
        logic [1:0]        act;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic              tc;
        logic              first;
        logic              spec;
        logic [POS_W-1:0]  pos;
    } fetch_cmd_t;

    typedef struct {
        logic               rvalid;
        logic [TAG_W-1:0]   tag;
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] nbytes;
        logic [TRACE_W-1:0] trace;
        logic               last;
    } queue_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    fetch_queue_squash_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // shadow copy of the queue contents and occupancy counters
    logic [TAG_W-1:0]  slot_tag  [DEPTH];
    logic [SIZE_W-1:0] slot_size [DEPTH];
    logic [2:0]        slot_flags[DEPTH];
    int                held       = 0;
    int                bytes_held = 0;
    int                trace_held = 0;

    fetch_cmd_t    fetch_cmds[$];
    queue_report_t queue_reports[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int errors        = 0;
    int n_queued      = 0;
    logic in_taken    = 1'b0;

    int n_by_act[4]    = '{default: 0};
    int n_beats        = 0;
    int n_full         = 0;
    int n_bad_pos      = 0;
    int n_squashed     = 0;
    int longest_squash = 0;

    function automatic void note_report(logic rv, logic [TAG_W-1:0] tag, status_t st);
        queue_report_t r;
        r.rvalid = rv;
        r.tag    = rv ? tag : '0;
        r.status = st;
        r.count  = COUNT_W'(held);
        r.nbytes = BYTES_W'(bytes_held);
        r.trace  = TRACE_W'(trace_held);
        r.last   = 1'b0;
        queue_reports.push_back(r);
    endfunction

    task automatic take_slot(input int pos, output logic [TAG_W-1:0] tag);
        logic [2:0] fl;
        tag = slot_tag[pos];
        fl  = slot_flags[pos];
        if (!fl[FLAG_TRACE_BIT] && fl[FLAG_FIRST_BIT])
            bytes_held = (bytes_held >= slot_size[pos]) ? bytes_held - slot_size[pos] : 0;
        if (fl[FLAG_TRACE_BIT])
            trace_held = (trace_held > 0) ? trace_held - 1 : 0;
        for (int i = pos; i + 1 < held; i++)
        begin
            slot_tag[i]   = slot_tag[i + 1];
            slot_size[i]  = slot_size[i + 1];
            slot_flags[i] = slot_flags[i + 1];
        end
        held--;
    endtask

    // apply one accepted command to the shadow queue and queue up its result beats
    task automatic queue_step(input fetch_cmd_t c);
        logic [TAG_W-1:0] t;
        int n;
        n = 0;
        n_by_act[c.act]++;
        case (c.act)
            ACT_PUSH:
            begin
                if (held >= DEPTH)
                begin
                    n_full++;
                    note_report(1'b0, '0, STAT_FULL);
                end
                else
                begin
                    slot_tag[held]   = c.tag;
                    slot_size[held]  = c.size;
                    slot_flags[held] = {c.spec, c.first, c.tc};
                    held++;
                    if (!c.tc && c.first)
                        bytes_held += c.size;
                    if (c.tc)
                        trace_held++;
                    note_report(1'b0, '0, STAT_OK);
                end
            end
            ACT_REMOVE:
            begin
                if (c.pos >= held)
                begin
                    n_bad_pos++;
                    note_report(1'b0, '0, STAT_BAD_POS);
                end
                else
                begin
                    take_slot(c.pos, t);
                    note_report(1'b1, t, STAT_OK);
                end
            end
            ACT_RECOVER:
            begin
                while (held > 0 && n < MAX_RESULTS && slot_flags[held - 1][FLAG_SPEC_BIT])
                begin
                    take_slot(held - 1, t);
                    note_report(1'b1, t, STAT_OK);
                    n++;
                end
                n_squashed += n;
                if (n > longest_squash)
                    longest_squash = n;
                if (n == 0)
                    note_report(1'b0, '0, STAT_OK);
            end
            default:
                note_report(1'b0, '0, STAT_OK);
        endcase
        queue_reports[queue_reports.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(string field, longint exp_v, longint got_v);
        errors++;
        $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
    endtask

    // input and output beats are both taken at the rising edge
    always @(posedge clk)
    begin
        queue_report_t e;
        queue_report_t g;
        fetch_cmd_t    c;
        cycle_cnt++;
        in_taken <= s_axis_tvalid && s_axis_tready && rst_n;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            c.act   = s_axis_tuser;
            c.tag   = s_axis_tdata[15:0];
            c.size  = s_axis_tdata[19:16];
            c.tc    = s_axis_tdata[20];
            c.first = s_axis_tdata[21];
            c.spec  = s_axis_tdata[22];
            c.pos   = s_axis_tdata[27:23];
            queue_step(c);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_beats++;
            g.rvalid = m_axis_tuser;
            g.tag    = m_axis_tdata[15:0];
            g.status = status_t'(m_axis_tdata[17:16]);
            g.count  = m_axis_tdata[23:18];
            g.nbytes = m_axis_tdata[32:24];
            g.trace  = m_axis_tdata[38:33];
            g.last   = m_axis_tlast;
            if (queue_reports.size() == 0)
            begin
                errors++;
                $display("%0t ns: result beat with nothing expected, got tag 0x%0h status %0d",
                         $time, g.tag, g.status);
            end
            else
            begin
                e = queue_reports.pop_front();
                if (g.rvalid !== e.rvalid) report_mismatch("removed_valid", e.rvalid, g.rvalid);
                if (g.tag !== e.tag)       report_mismatch("removed_tag", e.tag, g.tag);
                if (g.status !== e.status) report_mismatch("status", e.status, g.status);
                if (g.count !== e.count)   report_mismatch("entry_count", e.count, g.count);
                if (g.nbytes !== e.nbytes) report_mismatch("byte_occupancy", e.nbytes, g.nbytes);
                if (g.trace !== e.trace)   report_mismatch("trace_occupancy", e.trace, g.trace);
                if (g.last !== e.last)     report_mismatch("last", e.last, g.last);
            end
        end
    end

    // command driver
    always @(negedge clk)
    begin
        fetch_cmd_t c;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (fetch_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                c = fetch_cmds.pop_front();
                s_axis_tdata  <= {4'b0, c.pos, c.spec, c.first, c.tc, c.size, c.tag};
                s_axis_tuser  <= c.act;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off in the last phase
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served   <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic fetch_cmd_t rand_cmd(logic [1:0] act);
        fetch_cmd_t c;
        c.act   = act;
        c.tag   = TAG_W'($urandom);
        c.size  = SIZE_W'($urandom);
        c.tc    = 1'($urandom);
        c.first = 1'($urandom);
        c.spec  = 1'($urandom);
        c.pos   = POS_W'($urandom);
        return c;
    endfunction

    task automatic add_cmd(input fetch_cmd_t c);
        fetch_cmds.push_back(c);
        n_queued++;
    endtask

    task automatic add_push(input logic [TAG_W-1:0] tag, input logic [SIZE_W-1:0] size,
                            input logic tc, input logic first, input logic spec);
        fetch_cmd_t c;
        c       = rand_cmd(ACT_PUSH);
        c.tag   = tag;
        c.size  = size;
        c.tc    = tc;
        c.first = first;
        c.spec  = spec;
        add_cmd(c);
    endtask

    task automatic add_remove(input logic [POS_W-1:0] pos);
        fetch_cmd_t c;
        c     = rand_cmd(ACT_REMOVE);
        c.pos = pos;
        add_cmd(c);
    endtask

    // empty the queue, fill it with speculative entries past full, squash them all
    task automatic add_flood();
        repeat (DEPTH) add_remove('0);
        repeat (DEPTH + 1)
            add_push(TAG_W'($urandom), SIZE_W'($urandom), 1'($urandom), 1'($urandom), 1'b1);
        add_cmd(rand_cmd(ACT_RECOVER));
    endtask

    task automatic add_episode();
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                // committed entries followed by a speculative tail, then squash
                repeat ($urandom_range(1, 4))
                    add_push(TAG_W'($urandom), SIZE_W'($urandom), 1'($urandom),
                             1'($urandom), 1'b0);
                repeat ($urandom_range(1, 6))
                    add_push(TAG_W'($urandom), SIZE_W'($urandom), 1'($urandom),
                             1'($urandom), 1'b1);
                add_cmd(rand_cmd(ACT_RECOVER));
            end
            3:
                repeat ($urandom_range(20, 36)) add_cmd(rand_cmd(ACT_PUSH));
            4, 5:
                repeat ($urandom_range(1, 6))
                    add_remove(($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, 7))
                                                           : POS_W'($urandom));
            6, 7:
                repeat ($urandom_range(1, 4)) add_cmd(rand_cmd(2'($urandom)));
            8:
                add_cmd(rand_cmd(ACT_RECOVER));
            9:
                add_remove(POS_W'(DEPTH - 1));
            10:
                add_cmd(rand_cmd(ACT_UNUSED));
            default:
                add_flood();
        endcase
    endtask

    task automatic run_phase(input int items);
        int start;
        start = n_queued;
        while (n_queued - start < items)
            add_episode();
        while (fetch_cmds.size() != 0 || s_axis_tvalid || queue_reports.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_cnt, queue_reports.size());
        $display("** fetch_queue_squash_top: FAILED **");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 72;
        // empty queue corners, then a small mixed queue
        add_cmd(rand_cmd(ACT_RECOVER));
        add_remove('0);
        add_cmd(rand_cmd(ACT_UNUSED));
        add_push(16'h0000, 4'd0, 1'b0, 1'b0, 1'b0);
        add_push(16'hffff, 4'd15, 1'b0, 1'b1, 1'b0);
        add_push(16'h1234, 4'd15, 1'b1, 1'b1, 1'b0);
        add_push(16'h00ff, 4'd15, 1'b0, 1'b0, 1'b1);
        add_push(16'hff00, 4'd9, 1'b0, 1'b1, 1'b1);
        add_push(16'habcd, 4'd3, 1'b1, 1'b0, 1'b1);
        add_remove(5'd31);
        add_remove(5'd6);
        add_remove(5'd1);
        add_remove(5'd4);
        // squash stops at the first committed entry
        add_cmd(rand_cmd(ACT_RECOVER));
        add_cmd(rand_cmd(ACT_RECOVER));
        add_remove('0);
        add_cmd(rand_cmd(ACT_UNUSED));
        add_push(16'hffff, 4'd15, 1'b1, 1'b1, 1'b1);
        add_cmd(rand_cmd(ACT_RECOVER));
        add_remove('0);
        run_phase(PHASE_ITEMS);

        send_idle_pct = 72;
        recv_idle_pct = 32;
        run_phase(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        add_flood();
        run_phase(PHASE_ITEMS);

        repeat (40) @(posedge clk);
        $display("commands: %0d push (%0d full), %0d remove (%0d bad position), %0d recover, %0d unused",
                 n_by_act[ACT_PUSH], n_full, n_by_act[ACT_REMOVE], n_bad_pos,
                 n_by_act[ACT_RECOVER], n_by_act[ACT_UNUSED]);
        $display("result beats checked: %0d, entries squashed: %0d, longest squash: %0d, errors: %0d",
                 n_beats, n_squashed, longest_squash, errors);
        if (errors == 0 && queue_reports.size() == 0)
            $display("** fetch_queue_squash_top: PASSED **");
        else
            $display("** fetch_queue_squash_top: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/fqs_pkg.sv
hw/rtl/fetch_queue_squash_top.sv
sim/tb_fetch_queue_squash_top.sv
